// File: hdl/fwr_pkg.sv
// Package for the FIFO with remove-by-id block.
// Holds default sizes, command and status codes, and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package fwr_pkg;

  localparam int unsigned QueueDepthDef  = 16;
  localparam int unsigned IdBitsDef      = 16;
  localparam int unsigned PayloadBitsDef = 32;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_HEAD_RD,
    S_DONE
  } state_e;

endpackage

// File: hdl/fwr_ram.sv
// Record store for the FIFO with remove-by-id block.
// One write port, one read port with registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module fwr_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 48,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/fifo_with_remove_by_id.sv
// Bounded queue of (id, payload) records with push, pop and remove-by-id.
// Uses fwr_pkg and the record store fwr_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command item: push a
//   record, pop the head, or remove the first record whose id matches.
//   Output channel (out_valid_o / out_stall_i) returns one result item per
//   command: status, occupancy and the head record after the command.
//   Records sit in slot order, slot 0 is the head. The store has one read and
//   one write port; a single index counter and id comparator walk it.
//   Push, an unused command code and pop or remove on an empty queue go
//   straight to the head read. A search reads and compares each record
//   visited; closing the gap after a removal or pop reads and writes each
//   record moved, then drops the tail. The next item is taken once the
//   sequencer is back in idle after the result is loaded.
//   The block takes one command at a time; in_stall_o is low only while idle.
//   A finished result waits in the output register while the next command is
//   accepted; a second result waits in the sequencer until the first is taken.
//   Reset empties the queue; slot contents are not cleared, and head id and
//   payload read as zero while the queue is empty.
`timescale 1ns / 1ps

module fifo_with_remove_by_id #(
  parameter int unsigned QUEUE_DEPTH  = fwr_pkg::QueueDepthDef,
  parameter int unsigned ID_BITS      = fwr_pkg::IdBitsDef,
  parameter int unsigned PAYLOAD_BITS = fwr_pkg::PayloadBitsDef,
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              command_i,
  input  logic [ID_BITS-1:0]      process_id_i,
  input  logic [PAYLOAD_BITS-1:0] process_payload_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic [CntW-1:0]         occupancy_o,
  output logic                    head_valid_o,
  output logic [ID_BITS-1:0]      head_id_o,
  output logic [PAYLOAD_BITS-1:0] head_payload_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned RecW = ID_BITS + PAYLOAD_BITS;
  localparam logic [CntW-1:0] Full = CntW'(QUEUE_DEPTH);

  fwr_pkg::state_e  state_q, state_d;
  fwr_pkg::status_e status_q, status_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [ID_BITS-1:0] key_q, key_d;

  logic [CntW-1:0] idx_nxt;
  logic            at_last;
  logic            accept;
  logic            load;

  logic            ram_we;
  logic [PtrW-1:0] ram_waddr;
  logic [RecW-1:0] ram_wdata;
  logic            ram_re;
  logic [PtrW-1:0] ram_raddr;
  logic [RecW-1:0] ram_rdata;

  logic [ID_BITS-1:0]      rd_id;
  logic [PAYLOAD_BITS-1:0] rd_payload;

  logic                    out_valid_q;
  logic [1:0]              out_status_q;
  logic [CntW-1:0]         out_count_q;
  logic                    out_head_valid_q;
  logic [ID_BITS-1:0]      out_head_id_q;
  logic [PAYLOAD_BITS-1:0] out_head_payload_q;

  assign rd_id      = ram_rdata[RecW-1:PAYLOAD_BITS];
  assign rd_payload = ram_rdata[PAYLOAD_BITS-1:0];

  // Shared index unit: next slot and end-of-queue test
  assign idx_nxt = idx_q + CntW'(1);
  assign at_last = (idx_nxt >= count_q);

  assign in_stall_o = (state_q != fwr_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign load       = (state_q == fwr_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  fwr_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (RecW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fwr_pkg::S_IDLE;
      status_q <= fwr_pkg::ST_OK;
      count_q  <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    count_d   = count_q;
    idx_d     = idx_q;
    key_d     = key_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[PtrW-1:0];
    ram_wdata = {process_id_i, process_payload_i};
    ram_re    = 1'b0;
    ram_raddr = idx_q[PtrW-1:0];

    unique case (state_q)
      fwr_pkg::S_IDLE: begin
        if (accept) begin
          status_d = fwr_pkg::ST_OK;
          key_d    = process_id_i;
          idx_d    = '0;
          state_d  = fwr_pkg::S_HEAD_RD;
          unique case (command_i)
            fwr_pkg::CMD_PUSH: begin
              if (count_q == Full) begin
                status_d = fwr_pkg::ST_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            fwr_pkg::CMD_POP: begin
              if (count_q == '0) begin
                status_d = fwr_pkg::ST_EMPTY;
              end else begin
                state_d = fwr_pkg::S_SHIFT_RD;
              end
            end
            fwr_pkg::CMD_REMOVE: begin
              if (count_q == '0) begin
                status_d = fwr_pkg::ST_NOT_FOUND;
              end else begin
                state_d = fwr_pkg::S_SRCH_RD;
              end
            end
            default: begin
              state_d = fwr_pkg::S_HEAD_RD;
            end
          endcase
        end
      end
      fwr_pkg::S_SRCH_RD: begin
        ram_re  = 1'b1;
        state_d = fwr_pkg::S_SRCH_CMP;
      end
      fwr_pkg::S_SRCH_CMP: begin
        if (rd_id == key_q) begin
          state_d = fwr_pkg::S_SHIFT_RD;
        end else if (at_last) begin
          status_d = fwr_pkg::ST_NOT_FOUND;
          state_d  = fwr_pkg::S_HEAD_RD;
        end else begin
          idx_d   = idx_nxt;
          state_d = fwr_pkg::S_SRCH_RD;
        end
      end
      fwr_pkg::S_SHIFT_RD: begin
        // Pull the next record down one slot, or drop the tail when done
        if (at_last) begin
          count_d = count_q - CntW'(1);
          state_d = fwr_pkg::S_HEAD_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_nxt[PtrW-1:0];
          state_d   = fwr_pkg::S_SHIFT_WR;
        end
      end
      fwr_pkg::S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[PtrW-1:0];
        ram_wdata = ram_rdata;
        idx_d     = idx_nxt;
        state_d   = fwr_pkg::S_SHIFT_RD;
      end
      fwr_pkg::S_HEAD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = fwr_pkg::S_DONE;
      end
      fwr_pkg::S_DONE: begin
        if (load) begin
          state_d = fwr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fwr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q       <= status_q;
      out_count_q        <= count_q;
      out_head_valid_q   <= (count_q != '0);
      out_head_id_q      <= (count_q != '0) ? rd_id : '0;
      out_head_payload_q <= (count_q != '0) ? rd_payload : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign occupancy_o    = out_count_q;
  assign head_valid_o   = out_head_valid_q;
  assign head_id_o      = out_head_id_q;
  assign head_payload_o = out_head_payload_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("occupancy above queue depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CntW'(1)) ||
    (count_q + CntW'(1) == $past(count_q)))
    else $error("occupancy moved by more than one record");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("sequencer idle right after taking an item");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fwr_pkg::S_SHIFT_WR) |-> (idx_nxt < count_q))
    else $error("record move outside held slots");

  a_head_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_valid_o == (occupancy_o != '0)))
    else $error("head flag disagrees with occupancy");

endmodule
